// ===== src/text_terminal_grid_top_defines.svh =====
// Assertion macros for the terminal grid RTL.
`ifndef TEXT_TERMINAL_GRID_TOP_DEFINES_SVH
`define TEXT_TERMINAL_GRID_TOP_DEFINES_SVH

// Clocked check, off while reset is high.
`define TTG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check, also active during reset.
`define TTG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/ttg_pkg.sv =====
`default_nettype none

package ttg_pkg;

   localparam int ColW     = 8;
   localparam int RowW     = 7;
   localparam int AddrW    = ColW + RowW;
   localparam int MaxCols  = 1 << ColW;
   localparam int MaxRows  = 1 << RowW;
   localparam int MemDepth = MaxCols * MaxRows;

   localparam logic [8:0] ColsReset = 9'd80;
   localparam logic [7:0] RowsReset = 8'd25;
   localparam logic [8:0] ColsMax   = 9'(MaxCols);
   localparam logic [7:0] RowsMax   = 8'(MaxRows);

   localparam logic [7:0] ChNul = 8'h00;
   localparam logic [7:0] ChBs  = 8'h08;
   localparam logic [7:0] ChLf  = 8'h0A;
   localparam logic [7:0] ChCr  = 8'h0D;

   localparam logic OpPut  = 1'b0;
   localparam logic OpRead = 1'b1;

   localparam logic RegCols = 1'b0;
   localparam logic RegRows = 1'b1;

   typedef struct packed {
      logic            operation;
      logic [7:0]      char_code;
      logic [ColW-1:0] read_column;
      logic [RowW-1:0] read_row;
   } req_type;

   typedef struct packed {
      logic [ColW-1:0] cursor_column;
      logic [RowW-1:0] cursor_line;
      logic            did_scroll;
      logic [7:0]      cell_value;
      logic            read_error;
   } rsp_type;

   typedef struct packed {
      logic [ColW-1:0] col;
      logic [RowW-1:0] row;
      logic            scroll;
      logic            store;
   } step_type;

   typedef enum logic [5:0] {
      ST_CLR       = 6'b000001,
      ST_IDLE      = 6'b000010,
      ST_EXEC      = 6'b000100,
      ST_SCR_COPY  = 6'b001000,
      ST_SCR_DRAIN = 6'b010000,
      ST_SCR_CLR   = 6'b100000
   } state_type;

   function automatic logic [8:0] eff_cols(input logic [8:0] v);
      logic [8:0] r;
      r = v;
      if (v == 9'd0) r = 9'd1;
      else if (v > ColsMax) r = ColsMax;
      return r;
   endfunction

   function automatic logic [7:0] eff_rows(input logic [7:0] v);
      logic [7:0] r;
      r = v;
      if (v == 8'd0) r = 8'd1;
      else if (v > RowsMax) r = RowsMax;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/text_terminal_grid_top.sv =====
// Character terminal grid with cursor.
// Requests enter on req_item when start is high and busy is low. A request
// either puts one byte at the cursor (with newline, carriage return,
// backspace and NUL handling) or reads one cell of the grid.
// Every request gives one response on rsp_item, marked by rsp_strobe for a
// single cycle, registered from the execute state that follows the accepting
// edge. The receiver cannot stall; responses are never held.
// A new request is taken only once the last one has left the execute state;
// the 256 x 128 character memory has one read port and one write port. A
// request that scrolls keeps busy high while the memory copies each row up
// one cell per cycle and then clears the bottom row (with a single row, only
// the clear).
// Column and row counts are written over the APB port (register 0 at
// address 0, register 1 at address 4) by the user only while the block is
// idle, not enforced by the block; the cursor is clamped to the new size.
// After reset the block sweeps the whole memory to zero, one cell per
// cycle, with busy high; register writes are taken as usual.
`default_nettype none

`include "text_terminal_grid_top_defines.svh"

module text_terminal_grid_top
   import ttg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_item,
   output logic             rsp_strobe,
   output rsp_type          rsp_item,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [7:0] char_mem_ff [MemDepth];

   state_type       state_ff, state_in;
   logic [AddrW-1:0] clr_addr_ff, clr_addr_in;
   req_type         req_ff, req_in;
   logic            err_ff, err_in;
   logic [ColW-1:0] cur_col_ff, cur_col_in;
   logic [RowW-1:0] cur_row_ff, cur_row_in;
   logic [8:0]      cols_cfg_ff, cols_cfg_in;
   logic [7:0]      rows_cfg_ff, rows_cfg_in;
   logic [ColW-1:0] sc_col_ff, sc_col_in;
   logic [RowW-1:0] sc_row_ff, sc_row_in;
   logic            pend_valid_ff, pend_valid_in;
   logic [AddrW-1:0] pend_addr_ff, pend_addr_in;
   logic [7:0]      rd_data_ff;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_strobe_ff, rsp_strobe_in;

   logic             accept;
   logic             apb_wr;
   logic [8:0]       eff_c, eff_c_new;
   logic [7:0]       eff_r, eff_r_new;
   logic [8:0]       c_m1, c_m1_new;
   logic [7:0]       r_m1, r_m1_new;
   logic [ColW-1:0]  last_col;
   logic [RowW-1:0]  last_row;
   logic             wr_en;
   logic [AddrW-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [AddrW-1:0] rd_addr;
   step_type         step;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign pready     = 1'b1;
   assign apb_wr     = psel && penable && pwrite && pready;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   assign eff_c    = eff_cols(cols_cfg_ff);
   assign eff_r    = eff_rows(rows_cfg_ff);
   assign c_m1     = eff_c - 9'd1;
   assign r_m1     = eff_r - 8'd1;
   assign last_col = c_m1[ColW-1:0];
   assign last_row = r_m1[RowW-1:0];

   assign eff_c_new = eff_cols(cols_cfg_in);
   assign eff_r_new = eff_rows(rows_cfg_in);
   assign c_m1_new  = eff_c_new - 9'd1;
   assign r_m1_new  = eff_r_new - 8'd1;

   always_comb begin
      case (paddr[2])
         RegCols: prdata = {23'd0, cols_cfg_ff};
         RegRows: prdata = {24'd0, rows_cfg_ff};
         default: prdata = '0;
      endcase
   end

   ttg_cursor_step u_step (
      .cur_col   (cur_col_ff),
      .cur_row   (cur_row_ff),
      .char_code (req_ff.char_code),
      .eff_c     (eff_c),
      .eff_r     (eff_r),
      .step      (step)
   );

   assign rd_addr = (state_ff == ST_SCR_COPY) ? {sc_row_ff, sc_col_ff}
                                              : {req_item.read_row, req_item.read_column};

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      req_in        = req_ff;
      err_in        = err_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      cols_cfg_in   = cols_cfg_ff;
      rows_cfg_in   = rows_cfg_ff;
      sc_col_in     = sc_col_ff;
      sc_row_in     = sc_row_ff;
      pend_valid_in = (state_ff == ST_SCR_COPY);
      pend_addr_in  = pend_addr_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = clr_addr_ff;
      wr_data       = '0;

      case (state_ff)
         ST_CLR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + AddrW'(1);
            if (&clr_addr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_item;
               err_in   = ({1'b0, req_item.read_column} >= eff_c) ||
                          ({1'b0, req_item.read_row} >= eff_r);
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if (req_ff.operation == OpRead) begin
               rsp_in.cursor_column = cur_col_ff;
               rsp_in.cursor_line   = cur_row_ff;
               rsp_in.did_scroll    = 1'b0;
               rsp_in.cell_value    = err_ff ? 8'd0 : rd_data_ff;
               rsp_in.read_error    = err_ff;
            end else begin
               wr_en      = step.store;
               wr_addr    = {cur_row_ff, cur_col_ff};
               wr_data    = req_ff.char_code;
               cur_col_in = step.col;
               cur_row_in = step.row;
               rsp_in.cursor_column = step.col;
               rsp_in.cursor_line   = step.row;
               rsp_in.did_scroll    = step.scroll;
               rsp_in.cell_value    = 8'd0;
               rsp_in.read_error    = 1'b0;
               if (step.scroll) begin
                  sc_col_in = '0;
                  if (last_row == '0) begin
                     state_in = ST_SCR_CLR;
                  end else begin
                     sc_row_in = RowW'(1);
                     state_in  = ST_SCR_COPY;
                  end
               end
            end
         end
         ST_SCR_COPY: begin
            wr_en        = pend_valid_ff;
            wr_addr      = pend_addr_ff;
            wr_data      = rd_data_ff;
            pend_addr_in = {sc_row_ff - RowW'(1), sc_col_ff};
            if (sc_col_ff == last_col) begin
               sc_col_in = '0;
               if (sc_row_ff == last_row) state_in = ST_SCR_DRAIN;
               else sc_row_in = sc_row_ff + RowW'(1);
            end else begin
               sc_col_in = sc_col_ff + ColW'(1);
            end
         end
         ST_SCR_DRAIN: begin
            wr_en     = pend_valid_ff;
            wr_addr   = pend_addr_ff;
            wr_data   = rd_data_ff;
            sc_col_in = '0;
            state_in  = ST_SCR_CLR;
         end
         ST_SCR_CLR: begin
            wr_en   = 1'b1;
            wr_addr = {last_row, sc_col_ff};
            wr_data = '0;
            if (sc_col_ff == last_col) state_in = ST_IDLE;
            else sc_col_in = sc_col_ff + ColW'(1);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (apb_wr) begin
         case (paddr[2])
            RegCols: cols_cfg_in = pwdata[8:0];
            RegRows: rows_cfg_in = pwdata[7:0];
            default: ;
         endcase
      end
      if (apb_wr && ({1'b0, cur_col_in} >= eff_c_new)) cur_col_in = c_m1_new[ColW-1:0];
      if (apb_wr && ({1'b0, cur_row_in} >= eff_r_new)) cur_row_in = r_m1_new[RowW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         char_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= char_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLR;
         clr_addr_ff   <= '0;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         cols_cfg_ff   <= ColsReset;
         rows_cfg_ff   <= RowsReset;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         cols_cfg_ff   <= cols_cfg_in;
         rows_cfg_ff   <= rows_cfg_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      err_ff       <= err_in;
      sc_col_ff    <= sc_col_in;
      sc_row_ff    <= sc_row_in;
      pend_addr_ff <= pend_addr_in;
      rsp_ff       <= rsp_in;
   end

   `TTG_ASSERT(a_exec_gives_rsp, (state_ff == ST_EXEC) |=> rsp_strobe_ff, "no response after execute")
   `TTG_ASSERT(a_cursor_in_range, ({1'b0, cur_col_ff} < eff_c) && ({1'b0, cur_row_ff} < eff_r), "cursor outside grid")
   `TTG_ASSERT(a_err_cell_zero, (rsp_strobe_ff && rsp_ff.read_error) |-> (rsp_ff.cell_value == 8'd0), "error read with data")
   `TTG_ASSERT(a_scroll_busy, (rsp_strobe_ff && rsp_ff.did_scroll) |-> (state_ff == ST_SCR_COPY || state_ff == ST_SCR_CLR), "scroll response without scroll")
   `TTG_ASSERT_ALWAYS(a_idle_no_pend, (!reset && state_ff == ST_IDLE) |-> !pend_valid_ff, "copy write pending while idle")

endmodule

`default_nettype wire

// ===== src/ttg_cursor_step.sv =====
`default_nettype none

module ttg_cursor_step
   import ttg_pkg::*;
(
   input  wire logic [ColW-1:0] cur_col,
   input  wire logic [RowW-1:0] cur_row,
   input  wire logic [7:0]      char_code,
   input  wire logic [8:0]      eff_c,
   input  wire logic [7:0]      eff_r,
   output step_type             step
);

   logic [8:0] c_m1;
   logic [7:0] r_m1;
   logic [8:0] col_p1;
   logic [7:0] row_p1;

   assign c_m1   = eff_c - 9'd1;
   assign r_m1   = eff_r - 8'd1;
   assign col_p1 = {1'b0, cur_col} + 9'd1;
   assign row_p1 = {1'b0, cur_row} + 8'd1;

   always_comb begin
      step.col    = cur_col;
      step.row    = cur_row;
      step.scroll = 1'b0;
      step.store  = 1'b0;
      case (char_code)
         ChLf: begin
            step.col = '0;
            if (row_p1 >= eff_r) begin
               step.scroll = 1'b1;
               step.row    = r_m1[RowW-1:0];
            end else begin
               step.row = row_p1[RowW-1:0];
            end
         end
         ChCr: begin
            step.col = '0;
         end
         ChNul: begin
         end
         ChBs: begin
            if (cur_col != '0) begin
               step.col = cur_col - ColW'(1);
            end else if (cur_row != '0) begin
               step.row = cur_row - RowW'(1);
               step.col = c_m1[ColW-1:0];
            end
         end
         default: begin
            step.store = 1'b1;
            if (col_p1 >= eff_c) begin
               step.col = '0;
               if (row_p1 >= eff_r) begin
                  step.row    = r_m1[RowW-1:0];
                  step.scroll = 1'b1;
               end else begin
                  step.row = row_p1[RowW-1:0];
               end
            end else begin
               step.col = col_p1[ColW-1:0];
            end
         end
      endcase
   end

endmodule

`default_nettype wire
